FILE: hw/rtl/pci_pkg.sv
package pci_pkg;

	localparam int CNT_W   = 8;
	localparam int CHAN_W  = 6;
	localparam int COLOR_W = 3 * CHAN_W;

	localparam logic [CNT_W-1:0] FULL_CODE   = 8'd255;
	localparam logic [7:0]       LIMIT_RESET = 8'd50;

	typedef logic [COLOR_W-1:0] color_t;

	typedef struct packed {
		logic       start_image;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] pixel_index;
		logic       new_entry;
		logic       full_miss;
		logic       too_many_colors;
	} pix_out_t;

	typedef struct packed {
		logic load;
		logic step;
		logic commit;
	} pci_cmd_t;

	typedef struct packed {
		logic hit;
		logic exhausted;
		logic out_free;
	} pci_status_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} pci_state_t;

	function automatic color_t reduce_color(input pix_in_t px);
		return {px.red[7:2], px.green[7:2], px.blue[7:2]};
	endfunction

endpackage

FILE: hw/rtl/pci_ctrl.sv
module pci_ctrl
	import pci_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  pci_status_t status,
	output pci_cmd_t    cmd
);

	pci_state_t state_q;
	pci_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// hit or end of filled entries: hand off once the output slot frees
				if (status.hit || status.exhausted) begin
					if (status.out_free) begin
						cmd.commit = 1'b1;
						state_d    = ST_IDLE;
					end
				end else begin
					cmd.step = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: hw/rtl/pci_datapath.sv
module pci_datapath
	import pci_pkg::*;
#(
	parameter int PALETTE_DEPTH = 255
)
(
	input  logic        clk,
	input  logic        arst_n,
	input  pix_in_t     in_data,
	input  logic        cfg_valid,
	input  logic [7:0]  cfg_data,
	input  logic        out_ready,
	output logic        out_valid,
	output pix_out_t    out_data,
	input  pci_cmd_t    cmd,
	output pci_status_t status
);

	localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(PALETTE_DEPTH);

	color_t             palette_mem [PALETTE_DEPTH];
	color_t             color_q;
	color_t             rd_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   scan_q;
	logic [CNT_W-1:0]   cmp_idx_q;
	logic               cmp_valid_q;
	logic [7:0]         limit_q;
	logic               out_valid_q;
	pix_out_t           out_q;

	logic               hit;
	logic               exhausted;
	logic               full;
	logic               append;
	logic [CNT_W:0]     count_next;

	assign hit        = cmp_valid_q && (rd_q == color_q);
	assign exhausted  = (scan_q == count_q);
	assign full       = (count_q >= DEPTH_CNT);
	assign append     = cmd.commit && !hit && !full;
	assign count_next = {1'b0, count_q} + {{CNT_W{1'b0}}, append};

	assign status.hit       = hit;
	assign status.exhausted = exhausted;
	assign status.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk) begin
		if (append) begin
			palette_mem[count_q[AW-1:0]] <= color_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			rd_q      <= palette_mem[scan_q[AW-1:0]];
			cmp_idx_q <= scan_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			color_q <= reduce_color(in_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			scan_q      <= '0;
			cmp_valid_q <= 1'b0;
			limit_q     <= LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				limit_q <= cfg_data;
			end
			if (cmd.load) begin
				scan_q      <= '0;
				cmp_valid_q <= 1'b0;
				if (in_data.start_image) begin
					count_q <= '0;
				end
			end else if (cmd.step) begin
				scan_q      <= scan_q + CNT_W'(1);
				cmp_valid_q <= 1'b1;
			end
			if (append) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q.too_many_colors <= (count_next > {1'b0, limit_q});
			if (hit) begin
				out_q.pixel_index <= cmp_idx_q;
				out_q.new_entry   <= 1'b0;
				out_q.full_miss   <= 1'b0;
			end else if (full) begin
				out_q.pixel_index <= FULL_CODE;
				out_q.new_entry   <= 1'b0;
				out_q.full_miss   <= 1'b1;
			end else begin
				out_q.pixel_index <= count_q;
				out_q.new_entry   <= 1'b1;
				out_q.full_miss   <= 1'b0;
			end
		end
	end

endmodule

FILE: hw/rtl/palette_color_indexer.sv
// channel  direction  payload     transfer when
// in       input      pix_in_t    in_valid & in_ready
// out      output     pix_out_t   out_valid & out_ready
// cfg      input      8-bit limit cfg_valid & cfg_ready (always ready)
//
// a pixel's scan reads n palette entries, n being those up to and including a hit (all filled
// entries on a miss), and the next pixel can transfer only once that pixel has handed off;
// the single read port of the palette memory sets this pace, one entry per cycle
// reset clears the entry count and restores the limit to 50; palette contents are kept
// a result waits in the output register; the next pixel is taken meanwhile and its
// scan stalls only at the handoff while the output register is still full
module palette_color_indexer
	import pci_pkg::*;
#(
	parameter int PALETTE_DEPTH = 255
)
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  pix_in_t    in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output pix_out_t   out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	pci_cmd_t    cmd;
	pci_status_t status;

	assign cfg_ready = 1'b1;

	pci_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	pci_datapath #(
		.PALETTE_DEPTH (PALETTE_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

FILE: verif/tb_palette_color_indexer.sv
`timescale 1ns / 1ps

module tb_palette_color_indexer;
	import pci_pkg::*;

	localparam int PALETTE_DEPTH  = 255;
	localparam int RANDOM_PIXELS  = 1250;
	// slowest item is a full scan plus the long receiver hold
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TAIL_CYCLES    = 300;
	localparam int MAX_REPORTS    = 10;

	typedef struct packed {
		pix_in_t  px;
		logic     typed;
		pix_out_t res;
	} dir_row_t;

	localparam int DIR_ROWS = 18;
	localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
		// black first, count is zero out of reset
		'{'{1'b0, 8'h00, 8'h00, 8'h00}, 1'b1, '{8'd0, 1'b1, 1'b0, 1'b0}},
		// low two bits are dropped, so this hits entry 0
		'{'{1'b0, 8'h03, 8'h03, 8'h03}, 1'b1, '{8'd0, 1'b0, 1'b0, 1'b0}},
		'{'{1'b0, 8'hff, 8'hff, 8'hff}, 1'b1, '{8'd1, 1'b1, 1'b0, 1'b0}},
		'{'{1'b0, 8'hfc, 8'hfd, 8'hfe}, 1'b1, '{8'd1, 1'b0, 1'b0, 1'b0}},
		'{'{1'b0, 8'h04, 8'h00, 8'h00}, 1'b1, '{8'd2, 1'b1, 1'b0, 1'b0}},
		'{'{1'b0, 8'h00, 8'h04, 8'h00}, 1'b1, '{8'd3, 1'b1, 1'b0, 1'b0}},
		'{'{1'b0, 8'h00, 8'h00, 8'h04}, 1'b1, '{8'd4, 1'b1, 1'b0, 1'b0}},
		'{'{1'b0, 8'haa, 8'h55, 8'haa}, 1'b0, '{8'd0, 1'b0, 1'b0, 1'b0}},
		'{'{1'b0, 8'h55, 8'haa, 8'h55}, 1'b0, '{8'd0, 1'b0, 1'b0, 1'b0}},
		'{'{1'b0, 8'h80, 8'h40, 8'h20}, 1'b0, '{8'd0, 1'b0, 1'b0, 1'b0}},
		'{'{1'b0, 8'hab, 8'h56, 8'ha9}, 1'b0, '{8'd0, 1'b0, 1'b0, 1'b0}},
		// start together with a pixel: that pixel becomes entry 0
		'{'{1'b1, 8'hff, 8'hff, 8'hff}, 1'b1, '{8'd0, 1'b1, 1'b0, 1'b0}},
		'{'{1'b0, 8'h00, 8'h00, 8'h00}, 1'b1, '{8'd1, 1'b1, 1'b0, 1'b0}},
		'{'{1'b0, 8'hff, 8'hff, 8'hff}, 1'b1, '{8'd0, 1'b0, 1'b0, 1'b0}},
		'{'{1'b0, 8'h00, 8'h00, 8'h00}, 1'b1, '{8'd1, 1'b0, 1'b0, 1'b0}},
		'{'{1'b1, 8'h00, 8'h00, 8'h00}, 1'b1, '{8'd0, 1'b1, 1'b0, 1'b0}},
		'{'{1'b0, 8'h01, 8'h02, 8'h03}, 1'b1, '{8'd0, 1'b0, 1'b0, 1'b0}},
		'{'{1'b1, 8'h12, 8'h34, 8'h56}, 1'b0, '{8'd0, 1'b0, 1'b0, 1'b0}}
	};

	logic     clk = 1'b0;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	pix_in_t  in_data;
	logic     out_valid;
	logic     out_ready;
	pix_out_t out_data;
	logic     cfg_valid;
	logic     cfg_ready;
	logic [7:0] cfg_data;

	// typed expectation travels with the pixel it belongs to
	logic     row_typed;
	pix_out_t row_result;

	color_t      palette_model [PALETTE_DEPTH];
	int unsigned fill_level  = 0;
	logic [7:0]  limit_model = LIMIT_RESET;
	pix_out_t    awaited_indices [$];

	int unsigned pixels_sent     = 0;
	int unsigned results_checked = 0;
	int unsigned fail_count      = 0;
	int unsigned new_seen        = 0;
	int unsigned full_seen       = 0;
	int unsigned over_seen       = 0;
	int unsigned limit_writes    = 0;
	int unsigned quiet_cycles    = 0;
	bit          steady_stretch  = 1'b0;

	palette_color_indexer #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic pix_out_t index_pixel(input pix_in_t px);
		color_t   hue;
		pix_out_t res;
		int       slot;
		hue = {px.red[7:2], px.green[7:2], px.blue[7:2]};
		if (px.start_image)
			fill_level = 0;
		slot = -1;
		for (int k = 0; k < fill_level; k++)
			if (slot < 0 && palette_model[k] == hue)
				slot = k;
		res = '0;
		if (slot >= 0) begin
			res.pixel_index = 8'(slot);
		end else if (fill_level < PALETTE_DEPTH) begin
			palette_model[fill_level] = hue;
			res.pixel_index = 8'(fill_level);
			res.new_entry = 1'b1;
			fill_level++;
		end else begin
			res.pixel_index = FULL_CODE;
			res.full_miss = 1'b1;
		end
		res.too_many_colors = (fill_level > limit_model);
		return res;
	endfunction

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("mismatch: %s", msg);
	endtask

	always @(posedge clk) begin
		pix_out_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_checked++;
				new_seen  += out_data.new_entry;
				full_seen += out_data.full_miss;
				over_seen += out_data.too_many_colors;
				if (awaited_indices.size() == 0) begin
					note_failure($sformatf("result with no pixel waiting, index %0d",
						out_data.pixel_index));
				end else begin
					want = awaited_indices.pop_front();
					if (out_data.pixel_index != want.pixel_index ||
					    out_data.new_entry != want.new_entry ||
					    out_data.full_miss != want.full_miss ||
					    out_data.too_many_colors != want.too_many_colors)
						note_failure($sformatf({"result %0d: expected index %0d new %0b full %0b",
							" over %0b, got index %0d new %0b full %0b over %0b"},
							results_checked, want.pixel_index, want.new_entry,
							want.full_miss, want.too_many_colors, out_data.pixel_index,
							out_data.new_entry, out_data.full_miss,
							out_data.too_many_colors));
				end
			end
			if (in_valid && in_ready) begin
				want = index_pixel(in_data);
				if (row_typed)
					want = row_result;
				awaited_indices.push_back(want);
			end
			if (cfg_valid && cfg_ready)
				limit_model = cfg_data;
		end
	end

	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	// receiver: random stalls, one long hold-off so the block backs up
	initial begin
		int unsigned taken;
		int unsigned hold_left;
		bit          held_once;
		taken = 0;
		hold_left = 0;
		held_once = 1'b0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				taken++;
			if (!held_once && taken >= 60) begin
				held_once = 1'b1;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (steady_stretch) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= 15);
			end
		end
	end

	task automatic offer_pixel(input pix_in_t px, input logic typed, input pix_out_t res);
		if (!steady_stretch && $urandom_range(99) < 15) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		in_data    <= px;
		row_typed  <= typed;
		row_result <= res;
		do @(posedge clk); while (!in_ready);
		pixels_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (results_checked < pixels_sent)
			@(posedge clk);
	endtask

	task automatic write_limit(input logic [7:0] value);
		drain_results();
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		limit_writes++;
	endtask

	// one image: a start, a first pass over its color set, then repeats with
	// random low bits; some noise colors and stray starts mixed in
	task automatic run_image(input int unsigned n_pix, input int unsigned n_col,
	                         input int unsigned start_pct);
		color_t  color_set [$];
		color_t  c;
		pix_in_t px;
		for (int unsigned k = 0; k < n_col; k++)
			color_set.push_back(color_t'($urandom));
		for (int unsigned k = 0; k < n_pix; k++) begin
			if (k < n_col)
				c = color_set[k];
			else
				c = color_set[$urandom_range(n_col - 1)];
			if ($urandom_range(99) < 10)
				c = color_t'($urandom);
			px.start_image = (k == 0) || ($urandom_range(99) < start_pct);
			px.blue  = {c[5:0], 2'($urandom)};
			px.green = {c[11:6], 2'($urandom)};
			px.red   = {c[17:12], 2'($urandom)};
			offer_pixel(px, 1'b0, '0);
		end
	endtask

	initial begin
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		in_data    <= '0;
		cfg_valid  <= 1'b0;
		cfg_data   <= '0;
		row_typed  <= 1'b0;
		row_result <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows run at the reset limit
		for (int k = 0; k < DIR_ROWS; k++)
			offer_pixel(DIR_TABLE[k].px, DIR_TABLE[k].typed, DIR_TABLE[k].res);

		write_limit(8'd0);
		repeat (8)
			run_image($urandom_range(10, 30), $urandom_range(1, 12), 3);

		// fill the palette and keep going past full
		write_limit(8'd255);
		run_image(400, 300, 0);

		write_limit(8'($urandom_range(1, 30)));
		steady_stretch = 1'b1;
		repeat (10)
			run_image($urandom_range(15, 35), $urandom_range(1, 16), 3);
		steady_stretch = 1'b0;

		write_limit(8'd200);
		run_image(300, 260, 0);

		while (pixels_sent < DIR_ROWS + RANDOM_PIXELS) begin
			if ($urandom_range(99) < 15)
				write_limit(8'($urandom));
			if ($urandom_range(99) < 15)
				run_image(20, 20, 10);
			else
				run_image($urandom_range(5, 40), $urandom_range(1, 16), 3);
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (awaited_indices.size() != 0)
			note_failure($sformatf("%0d results never arrived", awaited_indices.size()));

		$display("run covered %0d pixels (%0d directed) over %0d limit settings",
			pixels_sent, DIR_ROWS, limit_writes);
		$display("seen %0d new entries, %0d full-palette misses, %0d over-limit flags, %0d failures",
			new_seen, full_seen, over_seen, fail_count);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/pci_pkg.sv
hw/rtl/pci_ctrl.sv
hw/rtl/pci_datapath.sv
hw/rtl/palette_color_indexer.sv
verif/tb_palette_color_indexer.sv
